>>> hw/rtl/cross_sharpen_3x3_stream_macros.svh
// Assertion macros used by the checker file of the sharpening stream.
`ifndef CROSS_SHARPEN_3X3_STREAM_MACROS_SVH
`define CROSS_SHARPEN_3X3_STREAM_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CSH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define CSH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/csh_pkg.sv
// Shared types and constants of the cross sharpening stream.
`timescale 1ns / 1ps

package csh_pkg;

   // Fixed field and register widths
   localparam int SAMPLE_W    = 8;
   localparam int ROW_OUT_W   = 12;
   localparam int COL_OUT_W   = 13;
   localparam int LB_REG_W    = 14;
   localparam int CH_REG_W    = 3;
   localparam int RT_REG_W    = 13;
   localparam int CSR_DATA_W  = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int OFF_W       = 3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_BYTES    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_TOTAL     = 2'd2;

   // Register reset values
   localparam logic [LB_REG_W-1:0] LINE_BYTES_RESET    = 14'd1920;
   localparam logic [CH_REG_W-1:0] CHANNEL_COUNT_RESET = 3'd1;
   localparam logic [RT_REG_W-1:0] ROW_TOTAL_RESET     = 13'd1080;

   // Usable register ranges
   localparam int LB_MIN = 3;
   localparam int RT_MIN = 3;
   localparam int CH_MIN = 1;
   localparam int CH_MAX = 4;

   // Stencil center weight
   localparam int CENTER_WEIGHT = 5;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_start;
   } csh_req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]  sharpened;
      logic [ROW_OUT_W-1:0] center_row;
      logic [COL_OUT_W-1:0] center_column;
      logic                 frame_done;
   } csh_rsp_type;

   // Per-word control handed from position tracking to the stencil stage
   typedef struct packed {
      logic                 produce;
      logic                 bank;
      logic [SAMPLE_W-1:0]  sample;
      logic [ROW_OUT_W-1:0] center_row;
      logic [COL_OUT_W-1:0] center_column;
      logic                 frame_done;
   } csh_tag_type;

endpackage

>>> hw/rtl/cross_sharpen_3x3_stream.sv
// Top level of the streaming 3x3 cross sharpening stencil.
//
//   channel   direction  handshake            word
//   req_      in         req_valid/req_stall  sample, frame_start
//   rsp_      out        rsp_valid/rsp_stall  sharpened, center_row, center_column, frame_done
//   csr_      in         csr_we               csr_index, csr_wdata (no read-back)
//
// One word is taken every cycle while req_stall is low; a result passes through the
// stencil stage register, fed by the registered line buffer reads, and the result register.
// req_stall rises only while both the stencil stage and the result register are full
// and rsp_stall is high. Synchronous reset clears counters and valids; the line
// buffers are not cleared, and each row is written before it is read.
`timescale 1ns / 1ps

module cross_sharpen_3x3_stream #(
   parameter int MAX_LINE_BYTES = 8192,
   parameter int MAX_ROWS       = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  csh_pkg::csh_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output csh_pkg::csh_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [csh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [csh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW = $clog2(MAX_LINE_BYTES);

   logic                         accept;
   csh_pkg::csh_tag_type         tag;
   logic [csh_pkg::OFF_W-1:0]    off;
   logic [CW-1:0]                col_addr;
   logic [CW-1:0]                nbr_addr;
   logic [1:0]                   wr_en;
   logic [csh_pkg::SAMPLE_W-1:0] ram0_a, ram0_b, ram1_a, ram1_b;

   assign accept = req_valid && !req_stall;

   // Counters, registers and buffer addressing
   csh_ctrl #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES),
      .MAX_ROWS       (MAX_ROWS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_data  (req_data),
      .tag       (tag),
      .off       (off),
      .col_addr  (col_addr),
      .nbr_addr  (nbr_addr),
      .wr_en     (wr_en)
   );

   // Two line buffers that trade older and newer roles each row
   csh_ram #(
      .WIDTH (csh_pkg::SAMPLE_W),
      .DEPTH (MAX_LINE_BYTES)
   ) u_line0 (
      .clock     (clock),
      .we        (wr_en[0]),
      .wr_addr   (col_addr),
      .wr_data   (req_data.sample),
      .re        (accept),
      .rd_addr_a (col_addr),
      .rd_addr_b (nbr_addr),
      .rd_data_a (ram0_a),
      .rd_data_b (ram0_b)
   );

   csh_ram #(
      .WIDTH (csh_pkg::SAMPLE_W),
      .DEPTH (MAX_LINE_BYTES)
   ) u_line1 (
      .clock     (clock),
      .we        (wr_en[1]),
      .wr_addr   (col_addr),
      .wr_data   (req_data.sample),
      .re        (accept),
      .rd_addr_a (col_addr),
      .rd_addr_b (nbr_addr),
      .rd_data_a (ram1_a),
      .rd_data_b (ram1_b)
   );

   // Stencil arithmetic and result register
   csh_stencil u_stencil (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .tag_in    (tag),
      .off       (off),
      .ram0_a    (ram0_a),
      .ram0_b    (ram0_b),
      .ram1_a    (ram1_a),
      .ram1_b    (ram1_b),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .req_stall (req_stall)
   );

endmodule

>>> hw/rtl/csh_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module csh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write, and read old contents on a same-address collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (re) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> hw/rtl/csh_ctrl.sv
// Configuration registers, row and column counters, line buffer addressing.
`timescale 1ns / 1ps

module csh_ctrl #(
   parameter int MAX_LINE_BYTES = 8192,
   parameter int MAX_ROWS       = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [csh_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [csh_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  accept,
   input  csh_pkg::csh_req_type                  req_data,
   output csh_pkg::csh_tag_type                  tag,
   output logic [csh_pkg::OFF_W-1:0]             off,
   output logic [$clog2(MAX_LINE_BYTES)-1:0]     col_addr,
   output logic [$clog2(MAX_LINE_BYTES)-1:0]     nbr_addr,
   output logic [1:0]                            wr_en
);

   localparam int CW  = $clog2(MAX_LINE_BYTES);
   localparam int LBW = CW + 1;
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int RTW = RW + 1;

   logic [csh_pkg::LB_REG_W-1:0] lb_ff, lb_in;
   logic [csh_pkg::CH_REG_W-1:0] ch_ff, ch_in;
   logic [csh_pkg::RT_REG_W-1:0] rt_ff, rt_in;
   logic [CW-1:0]                col_ff, col_in;
   logic [RW-1:0]                row_ff, row_in;
   logic                         bank_ff, bank_in;

   logic [LBW-1:0] lb_eff;
   logic [RTW-1:0] rt_eff;
   logic [CW-1:0]  c_cur;
   logic [RW-1:0]  r_cur;
   logic [LBW-1:0] c_ext;
   logic [LBW-1:0] c_plus_off;
   logic [LBW-1:0] c_next;
   logic [RTW-1:0] r_ext;
   logic [RTW-1:0] r_next;
   logic           row_wrap;
   logic           produce;
   logic           last_col;
   logic           last_row;

   // Decode register writes
   always_comb begin
      lb_in = lb_ff;
      ch_in = ch_ff;
      rt_in = rt_ff;
      if (csr_we) begin
         unique case (csr_index)
            csh_pkg::CSR_LINE_BYTES:    lb_in = csr_wdata[csh_pkg::LB_REG_W-1:0];
            csh_pkg::CSR_CHANNEL_COUNT: ch_in = csr_wdata[csh_pkg::CH_REG_W-1:0];
            csh_pkg::CSR_ROW_TOTAL:     rt_in = csr_wdata[csh_pkg::RT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers into their usable ranges
   always_comb begin
      if (32'(lb_ff) < 32'(csh_pkg::LB_MIN)) begin
         lb_eff = LBW'(csh_pkg::LB_MIN);
      end else if (32'(lb_ff) > 32'(MAX_LINE_BYTES)) begin
         lb_eff = LBW'(MAX_LINE_BYTES);
      end else begin
         lb_eff = LBW'(lb_ff);
      end
      if (32'(rt_ff) < 32'(csh_pkg::RT_MIN)) begin
         rt_eff = RTW'(csh_pkg::RT_MIN);
      end else if (32'(rt_ff) > 32'(MAX_ROWS)) begin
         rt_eff = RTW'(MAX_ROWS);
      end else begin
         rt_eff = RTW'(rt_ff);
      end
      if (32'(ch_ff) < 32'(csh_pkg::CH_MIN)) begin
         off = csh_pkg::OFF_W'(csh_pkg::CH_MIN);
      end else if (32'(ch_ff) > 32'(csh_pkg::CH_MAX)) begin
         off = csh_pkg::OFF_W'(csh_pkg::CH_MAX);
      end else begin
         off = csh_pkg::OFF_W'(ch_ff);
      end
   end

   // Position of the incoming word; a frame start restarts at the origin
   assign c_cur      = req_data.frame_start ? '0 : col_ff;
   assign r_cur      = req_data.frame_start ? '0 : row_ff;
   assign c_ext      = {1'b0, c_cur};
   assign r_ext      = {1'b0, r_cur};
   assign c_plus_off = c_ext + LBW'(off);
   assign c_next     = c_ext + LBW'(1);
   assign r_next     = r_ext + RTW'(1);
   assign row_wrap   = (c_next >= lb_eff);

   // Interior test for the center one row up
   assign produce  = (r_cur >= RW'(2)) && (r_ext < rt_eff) &&
                     (c_ext >= LBW'(off)) && (c_plus_off < lb_eff);
   assign last_col = ((c_plus_off + LBW'(1)) == lb_eff);
   assign last_row = (r_next == rt_eff);

   // Advance counters and swap buffer roles at the end of a row
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      bank_in = bank_ff;
      if (accept) begin
         if (row_wrap) begin
            col_in  = '0;
            row_in  = (r_next >= rt_eff) ? '0 : r_next[RW-1:0];
            bank_in = ~bank_ff;
         end else begin
            col_in  = c_next[CW-1:0];
            row_in  = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff   <= csh_pkg::LINE_BYTES_RESET;
         ch_ff   <= csh_pkg::CHANNEL_COUNT_RESET;
         rt_ff   <= csh_pkg::ROW_TOTAL_RESET;
         col_ff  <= '0;
         row_ff  <= '0;
         bank_ff <= 1'b0;
      end else begin
         lb_ff   <= lb_in;
         ch_ff   <= ch_in;
         rt_ff   <= rt_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         bank_ff <= bank_in;
      end
   end

   // Word control for the stencil stage
   always_comb begin
      tag.produce       = produce;
      tag.bank          = bank_ff;
      tag.sample        = req_data.sample;
      tag.center_row    = csh_pkg::ROW_OUT_W'(r_cur - RW'(1));
      tag.center_column = csh_pkg::COL_OUT_W'(c_cur);
      tag.frame_done    = last_row && last_col;
   end

   // Bank 0 holds the older row while bank_ff is low
   assign col_addr = c_cur;
   assign nbr_addr = c_plus_off[CW-1:0];
   assign wr_en[0] = accept && !bank_ff;
   assign wr_en[1] = accept && bank_ff;

endmodule

>>> hw/rtl/csh_stencil.sv
// Stencil stage: neighbor history, weighted sum, saturation, result register.
`timescale 1ns / 1ps

module csh_stencil (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  csh_pkg::csh_tag_type              tag_in,
   input  logic [csh_pkg::OFF_W-1:0]         off,
   input  logic [csh_pkg::SAMPLE_W-1:0]      ram0_a,
   input  logic [csh_pkg::SAMPLE_W-1:0]      ram0_b,
   input  logic [csh_pkg::SAMPLE_W-1:0]      ram1_a,
   input  logic [csh_pkg::SAMPLE_W-1:0]      ram1_b,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output csh_pkg::csh_rsp_type              rsp_data,
   output logic                              req_stall
);

   localparam int HIST_DEPTH = csh_pkg::CH_MAX;
   localparam int HIDX_W     = $clog2(HIST_DEPTH);
   localparam int SUM_W      = csh_pkg::SAMPLE_W + 4;

   logic                           s1_valid_ff, s1_valid_in;
   csh_pkg::csh_tag_type           tag_ff;
   logic [csh_pkg::SAMPLE_W-1:0]   hist_ff [HIST_DEPTH];
   logic                           out_valid_ff, out_valid_in;
   csh_pkg::csh_rsp_type           out_data_ff;

   logic                           advance;
   logic [HIDX_W-1:0]              off_idx;
   logic [csh_pkg::SAMPLE_W-1:0]   newer_c;
   logic [csh_pkg::SAMPLE_W-1:0]   newer_r;
   logic [csh_pkg::SAMPLE_W-1:0]   newer_l;
   logic [csh_pkg::SAMPLE_W-1:0]   older_c;
   logic [SUM_W-1:0]               weighted;
   logic [SUM_W-1:0]               minus;
   logic signed [SUM_W-1:0]        diff;
   logic [csh_pkg::SAMPLE_W-1:0]   sat;

   // Move the stage word on unless a full result register is stalled
   assign advance   = s1_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;

   // Select buffer roles; left neighbor comes from the history of this row
   assign newer_c = tag_ff.bank ? ram0_a : ram1_a;
   assign older_c = tag_ff.bank ? ram1_a : ram0_a;
   assign newer_r = tag_ff.bank ? ram0_b : ram1_b;
   assign off_idx = HIDX_W'(off - 3'd1);
   assign newer_l = hist_ff[off_idx];

   // Weighted center minus the four neighbors, clipped to a byte
   assign weighted = SUM_W'(csh_pkg::CENTER_WEIGHT) * SUM_W'(newer_c);
   assign minus    = SUM_W'(newer_l) + SUM_W'(newer_r) + SUM_W'(older_c) +
                     SUM_W'(tag_ff.sample);
   assign diff     = signed'(weighted - minus);

   always_comb begin
      if (diff < 0) begin
         sat = '0;
      end else if (diff > SUM_W'(255)) begin
         sat = '1;
      end else begin
         sat = diff[csh_pkg::SAMPLE_W-1:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = tag_ff.produce;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the word; the line buffer reads land alongside it
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= tag_in;
      end
   end

   // Shift the newer row's center values through the history
   always_ff @(posedge clock) begin
      if (advance) begin
         hist_ff[0] <= newer_c;
         for (int k = 1; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (advance && tag_ff.produce) begin
         out_data_ff.sharpened     <= sat;
         out_data_ff.center_row    <= tag_ff.center_row;
         out_data_ff.center_column <= tag_ff.center_column;
         out_data_ff.frame_done    <= tag_ff.frame_done;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> hw/rtl/csh_checker.sv
// Port-level checks of the sharpening stream, bound to the top level.
`timescale 1ns / 1ps
`include "cross_sharpen_3x3_stream_macros.svh"

module csh_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input csh_pkg::csh_rsp_type rsp_data
);

   // A stalled result word holds
   `CSH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result word changed while stalled")

   // Input backpressure only comes from a stalled, full result register
   `CSH_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without output backpressure")

   // Every result sits at an interior position
   `CSH_ASSERT(a_interior, clock, reset, rsp_valid |-> rsp_data.center_row != 0 && rsp_data.center_column != 0, "result at a border position")

   // A fresh result traces back to a word taken on the input
   `CSH_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2), "result without a matching input word")

   // Reset empties the result register
   `CSH_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind cross_sharpen_3x3_stream csh_checker u_csh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
